[src/signed_int_to_decimal_ascii_defines.svh]
// Assertion macros used by the checker of this block.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// Concurrent assertion that is switched off while reset is held low.
`define SIDA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Concurrent assertion that is also checked while reset is held low.
`define SIDA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/sida_pkg.sv]
`default_nettype none

package sida_pkg;

    // Width of the signed input value.
    localparam int VALUE_WIDTH = 32;
    // Input tdata is the value rounded up to whole bytes.
    localparam int DATA_W      = ((VALUE_WIDTH + 7) / 8) * 8;
    // Decimal digits of the largest magnitude, 2^(VALUE_WIDTH-1).
    localparam int NDIG        = (((VALUE_WIDTH - 1) * 1233) / 4096) + 1;
    localparam int BCD_W       = NDIG * 4;
    localparam int POS_W       = $clog2(NDIG);
    // Binary bits shifted into the BCD word per pipeline stage.
    localparam int STEP        = 4;
    localparam int NSTG        = (VALUE_WIDTH + STEP - 1) / STEP;
    localparam int PAD_W       = NSTG * STEP;

    localparam int CHAR_W      = 6;
    localparam int OUT_W       = 8;
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_NINE  = 6'd57;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

    typedef logic [NDIG-1:0][3:0] t_bcd;

    // One shift-and-add-three step of the binary to BCD conversion.
    function automatic t_bcd dd_step(input t_bcd bcd, input logic bit_in);
        t_bcd             adj;
        logic [BCD_W-1:0] flat;
        adj = bcd;
        for (int k = 0; k < NDIG; k++) begin
            if (adj[k] >= 4'd5) begin
                adj[k] = adj[k] + 4'd3;
            end
        end
        flat = adj;
        return t_bcd'({flat[BCD_W-2:0], bit_in});
    endfunction

endpackage

`default_nettype wire

[src/signed_int_to_decimal_ascii.sv]
// Signed integer to decimal ASCII text. Each input transfer carries one two's-complement
// value of VALUE_WIDTH bits in the low bits of s_axis_tdata (higher bits are ignored).
// The block returns its decimal text on the master side, one character per transfer,
// most significant first: a leading '-' for a negative value, no leading zeros, a lone
// '0' for zero, and the most negative value printed in full. tlast marks the final
// character of each number. The conversion runs through a pipeline of NSTG + 2 register
// stages (magnitude, NSTG shift-and-add-three stages of four bits each, leading digit
// search; ten stages at 32 bits) before a value reaches the character serialiser. The
// serialiser then emits one character per cycle while m_axis_tready is held high; the
// text of one value has one to eleven characters at 32 bits. Values queue in the
// pipeline while the serialiser is busy, and the slave side accepts a new value
// whenever the pipeline can advance.

`default_nettype none

module signed_int_to_decimal_ascii
    import sida_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // [VALUE_WIDTH-1:0] value, rest ignored
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata,   // [5:0] character, [7:6] zero
    output logic              m_axis_tlast    // last
);

    // Pipeline stage 0 holds the magnitude, stages 1 to NSTG the partial BCD word,
    // and stage NSTG+1 adds the position of the leading digit.
    logic                   r_v   [0:NSTG+1];
    logic                   r_neg [0:NSTG+1];
    t_bcd                   r_bcd [0:NSTG+1];
    logic [PAD_W-1:0]       r_bin [0:NSTG-1];
    logic [POS_W-1:0]       r_lead;
    logic [POS_W-1:0]       n_lead;

    logic [VALUE_WIDTH-1:0] w_raw;
    logic [VALUE_WIDTH-1:0] w_mag;
    logic                   w_neg;

    // Serialiser and output register.
    logic                   r_busy;
    logic                   r_sign_pend;
    logic [POS_W-1:0]       r_pos;
    t_bcd                   r_digits;
    logic                   r_ov;
    logic [CHAR_W-1:0]      r_char;
    logic                   r_last;

    logic                   w_move;
    logic                   w_out_load;
    logic                   w_ser_done;
    logic                   w_ser_load;

    // The whole pipeline advances together; it only halts when its final stage holds a
    // value that the serialiser cannot take yet.
    assign w_out_load    = !r_ov || m_axis_tready;
    assign w_ser_done    = r_busy && !r_sign_pend && (r_pos == '0) && w_out_load;
    assign w_ser_load    = !r_busy || w_ser_done;
    assign w_move        = !r_v[NSTG+1] || w_ser_load;
    assign s_axis_tready = w_move;

    // Magnitude at full width, so that the most negative value needs no extra bit.
    assign w_raw = s_axis_tdata[VALUE_WIDTH-1:0];
    assign w_neg = w_raw[VALUE_WIDTH-1];
    assign w_mag = w_neg ? (~w_raw + 1'b1) : w_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_move) begin
            r_v[0] <= s_axis_tvalid;
        end
        if (w_move) begin
            r_neg[0] <= w_neg;
            r_bcd[0] <= '0;
            r_bin[0] <= PAD_W'(w_mag);
        end
    end

    // Double-dabble stages: each shifts four magnitude bits into the BCD word.
    for (genvar s = 1; s <= NSTG; s++) begin : g_dd
        t_bcd             n_bcd;
        logic [PAD_W-1:0] n_bin;

        always_comb begin
            n_bcd = r_bcd[s-1];
            n_bin = r_bin[s-1];
            for (int j = 0; j < STEP; j++) begin
                n_bcd = dd_step(n_bcd, n_bin[PAD_W-1]);
                n_bin = {n_bin[PAD_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (w_move) begin
                r_v[s] <= r_v[s-1];
            end
            if (w_move) begin
                r_neg[s] <= r_neg[s-1];
                r_bcd[s] <= n_bcd;
            end
        end

        if (s < NSTG) begin : g_bin
            always_ff @(posedge i_clk) begin
                if (w_move) begin
                    r_bin[s] <= n_bin;
                end
            end
        end
    end

    // Position of the most significant non-zero digit; zero keeps position 0.
    always_comb begin
        n_lead = '0;
        for (int k = 0; k < NDIG; k++) begin
            if (r_bcd[NSTG][k] != 4'd0) begin
                n_lead = POS_W'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[NSTG+1] <= 1'b0;
        end else if (w_move) begin
            r_v[NSTG+1] <= r_v[NSTG];
        end
        if (w_move) begin
            r_neg[NSTG+1] <= r_neg[NSTG];
            r_bcd[NSTG+1] <= r_bcd[NSTG];
            r_lead        <= n_lead;
        end
    end

    // Serialiser: the sign first if there is one, then digits down to position 0.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_sign_pend <= 1'b0;
            r_pos       <= '0;
        end else if (w_ser_load && r_v[NSTG+1]) begin
            r_busy      <= 1'b1;
            r_sign_pend <= r_neg[NSTG+1];
            r_pos       <= r_lead;
        end else if (w_ser_done) begin
            r_busy <= 1'b0;
        end else if (r_busy && w_out_load) begin
            if (r_sign_pend) begin
                r_sign_pend <= 1'b0;
            end else begin
                r_pos <= r_pos - 1'b1;
            end
        end
        if (w_ser_load && r_v[NSTG+1]) begin
            r_digits <= r_bcd[NSTG+1];
        end
    end

    // Output register: the next character is taken while the previous one is handed on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_out_load) begin
            r_ov <= r_busy;
        end
        if (w_out_load) begin
            if (r_sign_pend) begin
                r_char <= ASCII_MINUS;
            end else begin
                r_char <= ASCII_ZERO + {2'b00, r_digits[r_pos]};
            end
            r_last <= !r_sign_pend && (r_pos == '0);
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {{(OUT_W - CHAR_W){1'b0}}, r_char};
    assign m_axis_tlast  = r_last;

endmodule

`default_nettype wire

[src/sida_checker.sv]
`default_nettype none

`include "signed_int_to_decimal_ascii_defines.svh"

module sida_checker
    import sida_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [OUT_W-1:0]  m_axis_tdata,
    input logic              m_axis_tlast
);

    `SIDA_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")
    `SIDA_ASSERT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output changed")
    `SIDA_ASSERT(a_char_range, i_clk, i_rst_n, m_axis_tvalid |-> (m_axis_tdata == OUT_W'(ASCII_MINUS)) || ((m_axis_tdata >= OUT_W'(ASCII_ZERO)) && (m_axis_tdata <= OUT_W'(ASCII_NINE))), "character out of range")
    `SIDA_ASSERT(a_minus_not_last, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata == OUT_W'(ASCII_MINUS)) |-> !m_axis_tlast, "sign flagged as last")

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
